[hw/rtl/assert_macros.svh]
// Assertion macros used by the step counter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PDM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PDM_CHECK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PDM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDM_CHECK(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/pdm_pkg.sv]
// Types and constants of the pedometer step counter.
package pdm_pkg;

    localparam int NUM_AXES = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_HI   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_LO   = 3'd6;

    localparam logic [1:0] LVL_IDLE = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd1;
    localparam logic [1:0] LVL_LOW  = 2'd2;

    localparam logic [1:0] LOCK_LOCKED = 2'd0;
    localparam logic [1:0] LOCK_SEARCH = 2'd1;
    localparam logic [1:0] LOCK_FRESH  = 2'd2;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_COUNTED     = 3'd1;
    localparam logic [2:0] EV_NOT_REGULAR = 3'd2;
    localparam logic [2:0] EV_SHORT       = 3'd3;
    localparam logic [2:0] EV_LONG        = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [7:0] CNT_MAX = 8'hFF;

    localparam int BLK_MAX_RST  = 0;
    localparam int BLK_MIN_RST  = 1000;
    localparam int BLK_MAX_SEED = -5000;
    localparam int BLK_MIN_SEED = 5000;
    localparam int SWING_RST    = 30;
    localparam int STEP_RST     = 5;
    localparam int STEP_STRONG  = 1800;
    localparam int STEP_WEAK    = 100;
    localparam int STEP_MUL     = 13;
    localparam int STEP_SHIFT   = 4;

    localparam logic [7:0]  WIN_MIN_RST    = 8'd10;
    localparam logic [7:0]  WIN_MAX_RST    = 8'd200;
    localparam logic [7:0]  LOCK_STEPS_RST = 8'd3;
    localparam logic [7:0]  MISS_LIMIT_RST = 8'd4;
    localparam logic [7:0]  BLOCK_LEN_RST  = 8'd20;
    localparam logic [11:0] SWING_HI_RST   = 12'd2000;
    localparam logic [11:0] SWING_LO_RST   = 12'd500;

    typedef struct packed {
        logic [7:0]  window_min_ticks;
        logic [7:0]  window_max_ticks;
        logic [7:0]  steps_to_lock;
        logic [7:0]  misses_to_unlock;
        logic [7:0]  block_len;
        logic [11:0] swing_strong;
        logic [11:0] swing_weak;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic block_end;
        logic adv_thr;
        logic end_thr;
        logic adv_hys;
    } lane_ctl_t;

    typedef struct packed {
        logic flag;
        logic low_swing;
    } lane_res_t;

    typedef struct packed {
        logic [31:0] total_steps;
        logic [2:0]  step_event;
        logic [1:0]  step_axis;
        logic [7:0]  steps_added;
    } result_t;

endpackage

[hw/rtl/pdm_ifs.sv]
// Valid/ready channel interfaces for samples and results.
interface pdm_sample_if #(parameter int SAMPLE_WIDTH = 12) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface pdm_result_if ();
    logic        valid;
    logic        ready;
    logic [31:0] total_steps;
    logic [2:0]  step_event;
    logic [1:0]  step_axis;
    logic [7:0]  steps_added;

    modport source (output valid, output total_steps, output step_event,
                    output step_axis, output steps_added, input ready);
    modport sink (input valid, input total_steps, input step_event,
                  input step_axis, input steps_added, output ready);
endinterface

[hw/rtl/pdm_lane.sv]
// One axis lane: block min/max, thresholds and hysteresis step detect.
module pdm_lane #(
    parameter int SAMPLE_WIDTH = 12,
    localparam int AW = (SAMPLE_WIDTH > 14) ? SAMPLE_WIDTH : 14,
    localparam int SW = AW + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pdm_pkg::lane_ctl_t             ctl,
    input  pdm_pkg::cfg_t                  cfg,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed [SW-1:0]           swing,
    output pdm_pkg::lane_res_t             res
);

    // stage 1: block extremes
    logic signed [AW-1:0] blk_max_reg, blk_min_reg;
    logic signed [AW-1:0] s_ext, mx_upd, mn_upd;
    logic signed [AW-1:0] mx1_reg, mn1_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_reg, s2_reg;

    // stage 2: thresholds
    logic signed [SW-1:0] vpp, dc, up_n, lo_n, step_mid, step_n, strong_ext, weak_ext;
    logic [SW+3:0]        prod;
    logic                 weak_n;
    logic signed [SW-1:0] swing_reg, up_reg, lo_reg, step_reg;
    logic                 weak_reg;

    // stage 3: hysteresis
    logic signed [SW-1:0]           s3;
    logic [1:0]                     lvl_reg, lvl_n;
    logic signed [SAMPLE_WIDTH-1:0] last_reg, run_reg, last_t, run_n, last_n;
    logic signed [SW:0]             diff, dabs;
    logic                           hit;
    logic                           flag3_reg, weak3_reg;
    logic signed [SW-1:0]           swing3_reg;

    assign s_ext  = AW'(sample);
    assign mx_upd = (s_ext > blk_max_reg) ? s_ext : blk_max_reg;
    assign mn_upd = (s_ext < blk_min_reg) ? s_ext : blk_min_reg;

    assign vpp  = SW'(mx1_reg) - SW'(mn1_reg);
    assign dc   = SW'(mn1_reg) + (vpp >>> 1);
    assign up_n = dc + ((SW'(mx1_reg) - dc) >>> 1);
    assign lo_n = dc - ((dc - SW'(mn1_reg)) >>> 1);

    assign strong_ext = $signed(SW'(cfg.swing_strong));
    assign weak_ext   = $signed(SW'(cfg.swing_weak));
    assign prod       = (SW+4)'($unsigned(vpp)) * (SW+4)'(pdm_pkg::STEP_MUL);
    assign step_mid   = $signed(SW'(prod >> pdm_pkg::STEP_SHIFT));

    always_comb
    begin
        weak_n = 1'b0;
        if (vpp >= strong_ext)
        begin
            step_n = SW'(pdm_pkg::STEP_STRONG);
        end
        else if (vpp >= weak_ext)
        begin
            step_n = step_mid;
        end
        else
        begin
            step_n = SW'(pdm_pkg::STEP_WEAK);
            weak_n = 1'b1;
        end
    end

    assign s3 = SW'(s2_reg);

    always_comb
    begin
        last_t = last_reg;
        lvl_n  = lvl_reg;
        run_n  = run_reg;
        if (s3 > up_reg)
        begin
            if (lvl_reg != pdm_pkg::LVL_HIGH)
            begin
                last_t = run_reg;
            end
            lvl_n = pdm_pkg::LVL_HIGH;
            if (s2_reg > run_reg)
            begin
                run_n = s2_reg;
            end
        end
        else if (s3 < lo_reg)
        begin
            if (lvl_reg != pdm_pkg::LVL_LOW)
            begin
                last_t = run_reg;
            end
            lvl_n = pdm_pkg::LVL_LOW;
            if (s2_reg < run_reg)
            begin
                run_n = s2_reg;
            end
        end
    end

    assign diff   = (SW+1)'(last_t) - (SW+1)'(run_n);
    assign dabs   = (diff < 0) ? -diff : diff;
    assign hit    = (dabs >= (SW+1)'(step_reg));
    assign last_n = hit ? run_n : last_t;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            mx1_reg <= mx_upd;
            mn1_reg <= mn_upd;
            s1_reg  <= sample;
        end
        if (ctl.adv_thr)
        begin
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_max_reg <= AW'(pdm_pkg::BLK_MAX_RST);
            blk_min_reg <= AW'(pdm_pkg::BLK_MIN_RST);
            swing_reg   <= SW'(pdm_pkg::SWING_RST);
            up_reg      <= '0;
            lo_reg      <= '0;
            step_reg    <= SW'(pdm_pkg::STEP_RST);
            weak_reg    <= 1'b0;
            lvl_reg     <= pdm_pkg::LVL_IDLE;
            last_reg    <= '0;
            run_reg     <= '0;
            flag3_reg   <= 1'b0;
            weak3_reg   <= 1'b0;
            swing3_reg  <= '0;
        end
        else
        begin
            if (ctl.accept)
            begin
                blk_max_reg <= ctl.block_end ? AW'(pdm_pkg::BLK_MAX_SEED) : mx_upd;
                blk_min_reg <= ctl.block_end ? AW'(pdm_pkg::BLK_MIN_SEED) : mn_upd;
            end
            if (ctl.adv_thr && ctl.end_thr)
            begin
                swing_reg <= vpp;
                up_reg    <= up_n;
                lo_reg    <= lo_n;
                step_reg  <= step_n;
                weak_reg  <= weak_n;
            end
            if (ctl.adv_hys)
            begin
                lvl_reg    <= lvl_n;
                run_reg    <= run_n;
                last_reg   <= last_n;
                flag3_reg  <= hit;
                weak3_reg  <= weak_reg;
                swing3_reg <= swing_reg;
            end
        end
    end

    assign swing         = swing3_reg;
    assign res.flag      = flag3_reg;
    assign res.low_swing = weak3_reg;

endmodule

[hw/rtl/pdm_merge.sv]
// Dominant-axis select and time-window qualifier with the result register.
module pdm_merge #(
    parameter int SWING_W = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  pdm_pkg::cfg_t             cfg,
    input  pdm_pkg::lane_res_t        res [pdm_pkg::NUM_AXES],
    input  logic signed [SWING_W-1:0] swing [pdm_pkg::NUM_AXES],
    output pdm_pkg::result_t          word
);

    logic [1:0]       axis;
    logic             hit;
    logic [7:0]       tick_reg, pend_reg, miss_reg;
    logic [1:0]       lock_reg;
    logic [31:0]      total_reg;
    logic [7:0]       tick_inc, pend_inc, miss_inc;
    logic [7:0]       tick_n, pend_n, miss_n, added;
    logic [1:0]       lock_n;
    logic [31:0]      total_n;
    logic [2:0]       ev;
    pdm_pkg::result_t word_reg;

    always_comb
    begin
        if (swing[0] >= swing[1] && swing[0] >= swing[2])
        begin
            axis = pdm_pkg::AXIS_X;
        end
        else if (swing[1] >= swing[0] && swing[1] >= swing[2])
        begin
            axis = pdm_pkg::AXIS_Y;
        end
        else
        begin
            axis = pdm_pkg::AXIS_Z;
        end
    end

    always_comb
    begin
        case (axis)
            pdm_pkg::AXIS_X: hit = res[0].flag && !res[0].low_swing;
            pdm_pkg::AXIS_Y: hit = res[1].flag && !res[1].low_swing;
            pdm_pkg::AXIS_Z: hit = res[2].flag && !res[2].low_swing;
            default:         hit = 1'b0;
        endcase
    end

    assign tick_inc = (tick_reg == pdm_pkg::CNT_MAX) ? tick_reg : tick_reg + 8'd1;
    assign pend_inc = (pend_reg == pdm_pkg::CNT_MAX) ? pend_reg : pend_reg + 8'd1;
    assign miss_inc = (miss_reg == pdm_pkg::CNT_MAX) ? miss_reg : miss_reg + 8'd1;

    always_comb
    begin
        tick_n  = tick_inc;
        pend_n  = pend_reg;
        miss_n  = miss_reg;
        lock_n  = lock_reg;
        total_n = total_reg;
        ev      = pdm_pkg::EV_NONE;
        added   = 8'd0;
        if (hit)
        begin
            tick_n = 8'd0;
            if (lock_reg == pdm_pkg::LOCK_FRESH)
            begin
                pend_n = pend_inc;
                lock_n = pdm_pkg::LOCK_SEARCH;
                miss_n = 8'd0;
                ev     = pdm_pkg::EV_NOT_REGULAR;
            end
            else if (tick_inc < cfg.window_min_ticks)
            begin
                ev = pdm_pkg::EV_SHORT;
                if (lock_reg == pdm_pkg::LOCK_LOCKED && miss_inc < cfg.misses_to_unlock)
                begin
                    miss_n = miss_inc;
                end
                else
                begin
                    miss_n = 8'd0;
                    lock_n = pdm_pkg::LOCK_SEARCH;
                    pend_n = 8'd1;
                end
            end
            else if (tick_inc > cfg.window_max_ticks)
            begin
                miss_n = 8'd0;
                lock_n = pdm_pkg::LOCK_SEARCH;
                pend_n = 8'd1;
                ev     = pdm_pkg::EV_LONG;
            end
            else
            begin
                miss_n = 8'd0;
                if (lock_reg == pdm_pkg::LOCK_LOCKED)
                begin
                    total_n = total_reg + 32'd1;
                    pend_n  = 8'd0;
                    added   = 8'd1;
                    ev      = pdm_pkg::EV_COUNTED;
                end
                else if (pend_inc >= cfg.steps_to_lock)
                begin
                    lock_n  = pdm_pkg::LOCK_LOCKED;
                    total_n = total_reg + 32'(pend_inc);
                    added   = pend_inc;
                    pend_n  = 8'd0;
                    ev      = pdm_pkg::EV_COUNTED;
                end
                else
                begin
                    pend_n = pend_inc;
                    ev     = pdm_pkg::EV_NOT_REGULAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            pend_reg  <= '0;
            miss_reg  <= '0;
            lock_reg  <= pdm_pkg::LOCK_FRESH;
            total_reg <= '0;
            word_reg  <= '0;
        end
        else if (adv)
        begin
            tick_reg             <= tick_n;
            pend_reg             <= pend_n;
            miss_reg             <= miss_n;
            lock_reg             <= lock_n;
            total_reg            <= total_n;
            word_reg.total_steps <= total_n;
            word_reg.step_event  <= ev;
            word_reg.step_axis   <= (ev != pdm_pkg::EV_NONE) ? axis : pdm_pkg::AXIS_X;
            word_reg.steps_added <= added;
        end
    end

    assign word = word_reg;

endmodule

[hw/rtl/accel_pedometer_step_counter.sv]
// Top level of the accelerometer pedometer step counter.
//
// sample: one 3-axis word per transfer (valid/ready). result: one word per
// sample with the running total, the step event, the axis and steps added.
// Config: cfg_we/cfg_index/cfg_data write port, to be written only while idle;
// the block itself does not enforce this. A result word passes the registered
// stages block min/max, thresholds, per-axis hysteresis and axis merge/qualifier.
// Throughput: one sample per cycle unless stalled; three axis lanes in parallel.
// Each stage moves on when the next one is empty or moving, so up to four
// words sit in the pipe while result is stalled; sample.ready drops only
// when all four are full. Reset loads config defaults and clears all
// counters, block extremes and thresholds at once; no clearing pass.
`include "assert_macros.svh"
module accel_pedometer_step_counter #(
    parameter int SAMPLE_WIDTH = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]      cfg_data,
    pdm_sample_if.sink                          sample,
    pdm_result_if.source                        result
);

    localparam int AW = (SAMPLE_WIDTH > 14) ? SAMPLE_WIDTH : 14;
    localparam int SW = AW + 1;

    pdm_pkg::cfg_t      cfg_reg;
    logic [7:0]         blk_cnt_reg;
    logic               blk_end;
    logic               end_thr_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               in_rdy, rdy2, rdy3, rdy4;
    logic               adv1, adv2, adv3, adv4;
    pdm_pkg::lane_ctl_t ctl;
    pdm_pkg::lane_res_t lane_res [pdm_pkg::NUM_AXES];
    logic signed [SW-1:0]           lane_swing [pdm_pkg::NUM_AXES];
    logic signed [SAMPLE_WIDTH-1:0] smp [pdm_pkg::NUM_AXES];
    pdm_pkg::result_t   word;

    assign rdy4   = !v4_reg || result.ready;
    assign rdy3   = !v3_reg || rdy4;
    assign rdy2   = !v2_reg || rdy3;
    assign in_rdy = !v1_reg || rdy2;
    assign adv1   = sample.valid && in_rdy;
    assign adv2   = v1_reg && rdy2;
    assign adv3   = v2_reg && rdy3;
    assign adv4   = v3_reg && rdy4;

    assign blk_end = ({1'b0, blk_cnt_reg} + 9'd1) >= {1'b0, cfg_reg.block_len};

    assign ctl.accept    = adv1;
    assign ctl.block_end = blk_end;
    assign ctl.adv_thr   = adv2;
    assign ctl.end_thr   = end_thr_reg;
    assign ctl.adv_hys   = adv3;

    assign smp[0] = sample.accel_x;
    assign smp[1] = sample.accel_y;
    assign smp[2] = sample.accel_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_min_ticks <= pdm_pkg::WIN_MIN_RST;
            cfg_reg.window_max_ticks <= pdm_pkg::WIN_MAX_RST;
            cfg_reg.steps_to_lock    <= pdm_pkg::LOCK_STEPS_RST;
            cfg_reg.misses_to_unlock <= pdm_pkg::MISS_LIMIT_RST;
            cfg_reg.block_len        <= pdm_pkg::BLOCK_LEN_RST;
            cfg_reg.swing_strong     <= pdm_pkg::SWING_HI_RST;
            cfg_reg.swing_weak       <= pdm_pkg::SWING_LO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdm_pkg::REG_WIN_MIN:    cfg_reg.window_min_ticks <= cfg_data[7:0];
                pdm_pkg::REG_WIN_MAX:    cfg_reg.window_max_ticks <= cfg_data[7:0];
                pdm_pkg::REG_LOCK_STEPS: cfg_reg.steps_to_lock    <= cfg_data[7:0];
                pdm_pkg::REG_MISS_LIMIT: cfg_reg.misses_to_unlock <= cfg_data[7:0];
                pdm_pkg::REG_BLOCK_LEN:  cfg_reg.block_len        <= cfg_data[7:0];
                pdm_pkg::REG_SWING_HI:   cfg_reg.swing_strong     <= cfg_data;
                pdm_pkg::REG_SWING_LO:   cfg_reg.swing_weak       <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_cnt_reg <= '0;
            end_thr_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                blk_cnt_reg <= blk_end ? 8'd0 : blk_cnt_reg + 8'd1;
                end_thr_reg <= blk_end;
                v1_reg      <= 1'b1;
            end
            else if (adv2)
            begin
                v1_reg <= 1'b0;
            end
            if (adv2)
            begin
                v2_reg <= 1'b1;
            end
            else if (adv3)
            begin
                v2_reg <= 1'b0;
            end
            if (adv3)
            begin
                v3_reg <= 1'b1;
            end
            else if (adv4)
            begin
                v3_reg <= 1'b0;
            end
            if (adv4)
            begin
                v4_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                v4_reg <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < pdm_pkg::NUM_AXES; g++)
    begin : g_lane
        pdm_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .cfg    (cfg_reg),
            .sample (smp[g]),
            .swing  (lane_swing[g]),
            .res    (lane_res[g])
        );
    end

    pdm_merge #(
        .SWING_W (SW)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv4),
        .cfg   (cfg_reg),
        .res   (lane_res),
        .swing (lane_swing),
        .word  (word)
    );

    assign sample.ready       = in_rdy;
    assign result.valid       = v4_reg;
    assign result.total_steps = word.total_steps;
    assign result.step_event  = word.step_event;
    assign result.step_axis   = word.step_axis;
    assign result.steps_added = word.steps_added;

    `PDM_ASSERT(a_total_tracks_added, clk, rst_n, adv4 |=> (word.total_steps == $past(word.total_steps) + 32'(word.steps_added)), "total does not advance by steps added")
    `PDM_ASSERT(a_added_only_counted, clk, rst_n, v4_reg && (word.steps_added != 8'd0) |-> (word.step_event == pdm_pkg::EV_COUNTED), "steps added without a counted event")
    `PDM_ASSERT(a_axis_zero_idle, clk, rst_n, v4_reg && (word.step_event == pdm_pkg::EV_NONE) |-> (word.step_axis == pdm_pkg::AXIS_X), "axis set on a word with no event")
    `PDM_CHECK(a_stall_only_full, clk, !in_rdy |-> (v1_reg && v2_reg && v3_reg && v4_reg), "input stalled with a free stage")

endmodule
